// ----- hw/rtl/cdq_pkg.sv -----
package cdq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic signed [31:0] t_word;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_POP_FRONT  = 2'd1,
        MODE_PUSH_REAR  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_RIGHT,
        CELL_SHIFT_LEFT,
        CELL_LOAD_TAIL
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_word    push_word;
    } t_cell_ctrl;

    typedef struct packed {
        t_mode mode;
        t_word push_value;
    } t_in;

    typedef struct packed {
        t_word            pop_value;
        t_status          status;
        logic [CNT_W-1:0] occupancy;
    } t_out;

endpackage

// ----- hw/rtl/cdq_cell.sv -----
module cdq_cell
    import cdq_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_word      i_left,
    input  t_word      i_right,
    input  logic       i_tail,
    output t_word      o_data
);

    t_word r_data;
    t_word n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            CELL_HOLD:        n_data = r_data;
            CELL_SHIFT_RIGHT: n_data = i_left;
            CELL_SHIFT_LEFT:  n_data = i_right;
            CELL_LOAD_TAIL:   n_data = i_tail ? i_ctrl.push_word : r_data;
            default:          n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- hw/rtl/circular_deque.sv -----
// Double-ended queue of DEPTH signed 32-bit words held as a row of cells in
// logical order, front in cell 0. A push at the front shifts the row toward
// the rear, a pop at the front shifts it toward the front, a rear push loads
// only the cell at the fill count, and a rear pop reads the cell just below it.
// One operation is taken every cycle; its result beat (popped word, status,
// new count) appears in the output register on the next cycle and the input
// stalls only during reset and while that register is full and stalled
// downstream. A push when full or a pop when empty leaves the contents
// unchanged. No clearing pass after reset.
module circular_deque
    import cdq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    t_out             r_out;
    t_out             n_out;
    t_cell_ctrl       cell_ctrl;
    t_word            cell_data [DEPTH];
    t_word            rear_word;
    logic             accept;
    logic             full;
    logic             empty;

    assign o_in_stall = !i_rst_n || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_cnt == CNT_W'(DEPTH));
    assign empty      = (r_cnt == '0);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word left_w;
        t_word right_w;

        if (g == 0) begin : g_first
            assign left_w = i_in.push_value;
        end else begin : g_mid_l
            assign left_w = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_w = cell_data[g];
        end else begin : g_mid_r
            assign right_w = cell_data[g+1];
        end

        cdq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl),
            .i_left  (left_w),
            .i_right (right_w),
            .i_tail  (r_cnt == CNT_W'(g)),
            .o_data  (cell_data[g])
        );
    end

    // rear word sits in the cell just below the count
    always_comb begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (r_cnt == CNT_W'(i + 1)) begin
                rear_word = rear_word | cell_data[i];
            end
        end
    end

    always_comb begin
        cell_ctrl.op        = CELL_HOLD;
        cell_ctrl.push_word = i_in.push_value;
        n_cnt               = r_cnt;
        n_out.pop_value     = '0;
        n_out.status        = ST_OK;
        case (i_in.mode)
            MODE_PUSH_FRONT: begin
                if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    cell_ctrl.op = CELL_SHIFT_RIGHT;
                    n_cnt        = r_cnt + 1'b1;
                end
            end
            MODE_PUSH_REAR: begin
                if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    cell_ctrl.op = CELL_LOAD_TAIL;
                    n_cnt        = r_cnt + 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (empty) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    cell_ctrl.op    = CELL_SHIFT_LEFT;
                    n_out.pop_value = cell_data[0];
                    n_cnt           = r_cnt - 1'b1;
                end
            end
            MODE_POP_REAR: begin
                if (empty) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    n_out.pop_value = rear_word;
                    n_cnt           = r_cnt - 1'b1;
                end
            end
            default: begin
                n_out.status = ST_OK;
            end
        endcase
        n_out.occupancy = n_cnt;
        if (!accept) begin
            cell_ctrl.op = CELL_HOLD;
            n_cnt        = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
